[src/boosted_tree_ensemble_classifier_top_defines.svh]
// assertion helpers for the classifier
`ifndef BOOSTED_TREE_ENSEMBLE_CLASSIFIER_TOP_DEFINES_SVH
`define BOOSTED_TREE_ENSEMBLE_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define BTE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define BTE_ASSERT(lbl, prop)
`define BTE_ASSERT_NXT(lbl, a, b)
`endif
`endif

[src/bte_pkg.sv]
package bte_pkg;
  localparam int MAX_TREES      = 8;
  localparam int NODES_PER_TREE = 256;
  localparam int NUM_FEATURES   = 256;
  localparam int NUM_CLASSES    = 8;

  localparam int TREE_W  = $clog2(MAX_TREES);
  localparam int TCNT_W  = $clog2(MAX_TREES + 1);
  localparam int NODE_W  = $clog2(NODES_PER_TREE);
  localparam int FEAT_W  = $clog2(NUM_FEATURES);
  localparam int CLASS_W = $clog2(NUM_CLASSES);
  localparam int VALUE_W = 32;
  localparam int WGT_W   = 17;
  localparam int VOTE_W  = 20;

  localparam logic [WGT_W-1:0]  ONE_Q16  = 17'd65536;
  localparam logic [VOTE_W-1:0] VOTE_MAX = 20'hFFFFF;

  localparam logic [2:0] CMD_NODE     = 3'd0;
  localparam logic [2:0] CMD_LEAF     = 3'd1;
  localparam logic [2:0] CMD_WEIGHT   = 3'd2;
  localparam logic [2:0] CMD_FEATURE  = 3'd3;
  localparam logic [2:0] CMD_CLASSIFY = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_WALK  = 2'd1;
  localparam logic [1:0] STATUS_NOVOTE = 2'd2;

  typedef struct packed {
    logic                      leaf;
    logic [7:0]                feature;
    logic signed [VALUE_W-1:0] threshold;
    logic [7:0]                left;
    logic [7:0]                right;
  } node_t;
endpackage

[src/boosted_tree_ensemble_classifier_top.sv]
// weighted-vote classifier for a boosted tree ensemble. load commands (node,
// leaf probability, tree weight, feature) leave busy low. a classify
// command raises busy and walks the trees in use one after another through
// the node memory: per tree a start step, then for each inner node a node
// read followed by a feature read, then at the leaf the class probability
// scan and the vote add; a walk that hits the limit ends after its last
// inner node. after the last tree, a step to see that the trees are done
// and the final argmax over the class votes. the memory read latency sets
// this pace.
// the result shows on out_* with out_strobe high for exactly one cycle and
// must be taken then: there is no backpressure on the result side. the
// feature store and votes are cleared at that point, ready for the next
// document. cfg_ready is always high; write trees_in_use only while idle.
module boosted_tree_ensemble_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_tree_sel,
  input  logic [7:0]  in_node_sel,
  input  logic        in_leaf_flag,
  input  logic [7:0]  in_feature_sel,
  input  logic signed [31:0] in_value_q,
  input  logic [7:0]  in_left_child,
  input  logic [7:0]  in_right_child,
  input  logic [2:0]  in_class_sel,
  input  logic [16:0] in_weight_q,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [2:0]  out_top_class,
  output logic [19:0] out_top_score
);
  import bte_pkg::*;
  `include "boosted_tree_ensemble_classifier_top_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TREE = 3'd1;
  localparam logic [2:0] S_NODE = 3'd2;
  localparam logic [2:0] S_FEAT = 3'd3;
  localparam logic [2:0] S_LEAF = 3'd4;
  localparam logic [2:0] S_VOTE = 3'd5;
  localparam logic [2:0] S_ARG  = 3'd6;

  logic [2:0]          state_r;
  logic [3:0]          trees_r;
  logic [TCNT_W-1:0]   tree_r;
  logic [NODE_W-1:0]   node_r;
  logic [NODE_W-1:0]   visit_r;
  logic [CLASS_W-1:0]  cls_r;
  logic [WGT_W-1:0]    lbest_r;
  logic [CLASS_W-1:0]  lcls_r;
  logic                lhit_r;
  logic                fault_r;
  logic [VOTE_W-1:0]   votes_r [NUM_CLASSES];
  logic [VOTE_W-1:0]   abest_r;
  logic [CLASS_W-1:0]  atop_r;

  logic                accept;
  logic [TCNT_W-1:0]   ntrees;
  logic [WGT_W-1:0]    wsat;
  node_t               node_wdata;
  node_t               node_rd;
  logic                node_re;
  logic [TREE_W+NODE_W-1:0] node_raddr;
  logic [NODE_W-1:0]   next_node;
  logic [CLASS_W-1:0]  rcls;
  logic [WGT_W-1:0]    leaf_rd;
  logic [WGT_W-1:0]    wgt_rd;
  logic signed [VALUE_W-1:0] feat_rd;
  logic                feat_clr;
  logic [VOTE_W:0]     vote_sum;
  logic                arg_gt;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // register values above the tree count act as the full count
  assign ntrees = (trees_r > 4'(MAX_TREES)) ? TCNT_W'(MAX_TREES) : TCNT_W'(trees_r);
  assign wsat   = (in_weight_q > ONE_Q16) ? ONE_Q16 : in_weight_q;

  assign node_wdata = '{leaf: in_leaf_flag, feature: in_feature_sel, threshold: in_value_q,
                        left: in_left_child, right: in_right_child};

  // go left when the feature value is at most the threshold
  assign next_node = (feat_rd <= node_rd.threshold) ? node_rd.left : node_rd.right;

  assign node_re    = (state_r == S_TREE) || (state_r == S_FEAT);
  assign node_raddr = {tree_r[TREE_W-1:0], (state_r == S_TREE) ? '0 : next_node};
  assign rcls       = (state_r == S_LEAF) ? cls_r + 1'b1 : '0;
  assign feat_clr   = (state_r == S_ARG) && (cls_r == CLASS_W'(NUM_CLASSES-1));

  assign vote_sum = {1'b0, votes_r[lcls_r]} + (VOTE_W+1)'(wgt_rd);
  assign arg_gt   = votes_r[cls_r] > abest_r;

  bte_model_mem u_model (
    .clk        (clk),
    .node_we    (accept && in_cmd == CMD_NODE),
    .node_waddr ({in_tree_sel, in_node_sel}),
    .node_wdata (node_wdata),
    .node_re    (node_re),
    .node_raddr (node_raddr),
    .node_rdata (node_rd),
    .leaf_we    (accept && in_cmd == CMD_LEAF),
    .leaf_waddr ({in_tree_sel, in_node_sel, in_class_sel}),
    .leaf_wdata (wsat),
    .leaf_raddr ({tree_r[TREE_W-1:0], node_r, rcls}),
    .leaf_rdata (leaf_rd),
    .wgt_we     (accept && in_cmd == CMD_WEIGHT),
    .wgt_waddr  (in_tree_sel),
    .wgt_wdata  (wsat),
    .wgt_raddr  (tree_r[TREE_W-1:0]),
    .wgt_rdata  (wgt_rd)
  );

  bte_feat_mem u_feat (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (accept && in_cmd == CMD_FEATURE),
    .waddr (in_feature_sel),
    .wdata (in_value_q),
    .clr   (feat_clr),
    .raddr (node_rd.feature),
    .rdata (feat_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trees_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      trees_r <= cfg_data;
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) votes_r[i] <= '0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_cmd == CMD_CLASSIFY) begin
            tree_r  <= '0;
            fault_r <= 1'b0;
            state_r <= S_TREE;
          end
        end
        S_TREE: begin
          if (tree_r >= ntrees) begin
            cls_r   <= '0;
            abest_r <= '0;
            atop_r  <= '0;
            state_r <= S_ARG;
          end else begin
            node_r  <= '0;
            visit_r <= '0;
            state_r <= S_NODE;
          end
        end
        S_NODE: begin
          if (node_rd.leaf) begin
            cls_r   <= '0;
            lbest_r <= '0;
            lhit_r  <= 1'b0;
            state_r <= S_LEAF;
          end else begin
            state_r <= S_FEAT;
          end
        end
        S_FEAT: begin
          if (visit_r == NODE_W'(NODES_PER_TREE-1)) begin
            // walk limit reached without a leaf
            fault_r <= 1'b1;
            tree_r  <= tree_r + 1'b1;
            state_r <= S_TREE;
          end else begin
            visit_r <= visit_r + 1'b1;
            node_r  <= next_node;
            state_r <= S_NODE;
          end
        end
        S_LEAF: begin
          if (leaf_rd > lbest_r) begin
            lbest_r <= leaf_rd;
            lcls_r  <= cls_r;
            lhit_r  <= 1'b1;
          end
          if (cls_r == CLASS_W'(NUM_CLASSES-1)) begin
            state_r <= S_VOTE;
          end else begin
            cls_r <= cls_r + 1'b1;
          end
        end
        S_VOTE: begin
          if (lhit_r) begin
            votes_r[lcls_r] <= vote_sum[VOTE_W] ? VOTE_MAX : vote_sum[VOTE_W-1:0];
          end
          tree_r  <= tree_r + 1'b1;
          state_r <= S_TREE;
        end
        S_ARG: begin
          if (arg_gt) begin
            abest_r <= votes_r[cls_r];
            atop_r  <= cls_r;
          end
          if (cls_r == CLASS_W'(NUM_CLASSES-1)) begin
            out_strobe    <= 1'b1;
            out_top_class <= arg_gt ? cls_r : atop_r;
            out_top_score <= arg_gt ? votes_r[cls_r] : abest_r;
            if (fault_r) begin
              out_status <= STATUS_WALK;
            end else if (!arg_gt && abest_r == '0) begin
              out_status <= STATUS_NOVOTE;
            end else begin
              out_status <= STATUS_OK;
            end
            for (int i = 0; i < NUM_CLASSES; i++) votes_r[i] <= '0;
            state_r <= S_IDLE;
          end else begin
            cls_r <= cls_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BTE_ASSERT_NXT(a_classify_busy, accept && in_cmd == CMD_CLASSIFY, busy)
  `BTE_ASSERT_NXT(a_single_strobe, out_strobe, !out_strobe)
  `BTE_ASSERT(a_ok_has_score, (out_strobe && out_status == STATUS_OK) |-> (out_top_score != '0))
  `BTE_ASSERT(a_strobe_idle, out_strobe |-> !busy)
endmodule

[src/bte_model_mem.sv]
module bte_model_mem (
  input  logic                                 clk,
  input  logic                                 node_we,
  input  logic [bte_pkg::TREE_W+bte_pkg::NODE_W-1:0] node_waddr,
  input  bte_pkg::node_t                       node_wdata,
  input  logic                                 node_re,
  input  logic [bte_pkg::TREE_W+bte_pkg::NODE_W-1:0] node_raddr,
  output bte_pkg::node_t                       node_rdata,
  input  logic                                 leaf_we,
  input  logic [bte_pkg::TREE_W+bte_pkg::NODE_W+bte_pkg::CLASS_W-1:0] leaf_waddr,
  input  logic [bte_pkg::WGT_W-1:0]            leaf_wdata,
  input  logic [bte_pkg::TREE_W+bte_pkg::NODE_W+bte_pkg::CLASS_W-1:0] leaf_raddr,
  output logic [bte_pkg::WGT_W-1:0]            leaf_rdata,
  input  logic                                 wgt_we,
  input  logic [bte_pkg::TREE_W-1:0]           wgt_waddr,
  input  logic [bte_pkg::WGT_W-1:0]            wgt_wdata,
  input  logic [bte_pkg::TREE_W-1:0]           wgt_raddr,
  output logic [bte_pkg::WGT_W-1:0]            wgt_rdata
);
  import bte_pkg::*;

  node_t            node_mem [MAX_TREES*NODES_PER_TREE];
  logic [WGT_W-1:0] leaf_mem [MAX_TREES*NODES_PER_TREE*NUM_CLASSES];
  logic [WGT_W-1:0] wgt_mem  [MAX_TREES];

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
    leaf_rdata <= leaf_mem[leaf_raddr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[wgt_waddr] <= wgt_wdata;
    wgt_rdata <= wgt_mem[wgt_raddr];
  end
endmodule

[src/bte_feat_mem.sv]
module bte_feat_mem (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                we,
  input  logic [bte_pkg::FEAT_W-1:0]          waddr,
  input  logic signed [bte_pkg::VALUE_W-1:0]  wdata,
  input  logic                                clr,
  input  logic [bte_pkg::FEAT_W-1:0]          raddr,
  output logic signed [bte_pkg::VALUE_W-1:0]  rdata
);
  import bte_pkg::*;

  logic signed [VALUE_W-1:0] mem [NUM_FEATURES];
  logic [NUM_FEATURES-1:0]   valid_r;
  logic                      rvalid_r;
  logic signed [VALUE_W-1:0] rdata_r;

  // unwritten features read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r  <= mem[raddr];
    rvalid_r <= valid_r[raddr];
  end

  assign rdata = rvalid_r ? rdata_r : '0;
endmodule
